// ===== rtl/text_console_scrollback_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console scrollback
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLLBACK_DEFINES_SVH
`define TEXT_CONSOLE_SCROLLBACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Text console scrollback package
// Geometry, field widths, character codes, commands and sequencer states.
// ---------------------------------------------------------------------------
package tcs_pkg;

  // Console geometry.
  localparam int COLUMNS     = 80;
  localparam int STORE_ROWS  = 128;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = COLUMNS * STORE_ROWS;

  // Internal widths derived from the geometry.
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = COL_W + 1;
  localparam int ROW_W  = $clog2(STORE_ROWS);
  localparam int PHYS_W = ROW_W + 1;
  localparam int SUM_W  = ((ROW_W > 7) ? ROW_W : 7) + 1;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Field widths of the item channels.
  localparam int CMD_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int OFFSET_W   = 7;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int RCOLX_W    = RCOL_W + 1;
  localparam int POS_W      = 7;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - (3 * POS_W + CELL_W);

  // Cell and character constants.
  localparam logic [CELL_W-1:0] BLANK_WORD   = 16'h0F20;
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_END = 8'h80;
  localparam int                TAB_STEP     = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_VIEW_UP   = 3'd1,
    CMD_VIEW_DOWN = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACCESS,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/text_console_scrollback.sv =====
// One item at a time: a new item is accepted only after the last result is loaded.
// A printable character landing in a row not yet written since reset, clear or
// scroll first blanks that row through the single store write port.
// Scroll moves a ring base; clear and reset drop per-row valid marks at once.
// Reset (rst_n, synchronous) clears cursor, view, ring base, row marks and the
// output valid flag; the store itself needs no clearing pass.
// ---------------------------------------------------------------------------
// Text console scrollback
// Character console over a ring of STORE_ROWS rows held in one synchronous
// store, with view control and cell read-back through a four-step sequencer.
// ---------------------------------------------------------------------------
`include "text_console_scrollback_defines.svh"

module text_console_scrollback import tcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // char_code[7:0], back_nibble[11:8], fore_nibble[15:12], view_offset[22:16],
  // read_row[27:23], read_col[34:28], zero fill above.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[2:0].
  input  logic [CMD_W-1:0]      in_tuser,
  // end_of_text.
  input  logic                  in_tlast,
  // Result item channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cursor_col[6:0], cursor_line[13:7], view_top[20:14], cell_word[36:21],
  // zero fill above.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Sequencer state.
  state_t state_r, state_nxt;

  // Latched item.
  cmd_t                cmd_r;
  logic [CHAR_W-1:0]   char_r;
  logic [COLOR_W-1:0]  back_r;
  logic [COLOR_W-1:0]  fore_r;
  logic                eot_r;
  logic [OFFSET_W-1:0] off_r;
  logic [RROW_W-1:0]   rrow_r;
  logic [RCOL_W-1:0]   rcol_r;

  // Console state.
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [ROW_W-1:0]      view_r, view_nxt;
  logic [ROW_W-1:0]      base_r, base_nxt;
  logic [STORE_ROWS-1:0] valid_r;
  logic                  scroll;

  // Access stage registers.
  logic [ROW_W-1:0]  row_phys_r;
  logic              in_range_r;
  logic [COL_W-1:0]  sweep_cnt_r;
  logic              read_hit_r;
  logic [CELL_W-1:0] rd_data_r;

  // Output register.
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Text store.
  logic [CELL_W-1:0] store_mem [CELL_COUNT];

  // Control strobes.
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              exec_step;
  logic              commit;
  logic              need_sweep;
  logic              is_print;
  logic              row_valid;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] row_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] wr_data;
  logic [CELL_W-1:0] cell_word;

  // Row mapping in the execute step.
  logic [SUM_W-1:0]  srow_sum;
  logic              read_in_range;
  logic [ROW_W-1:0]  lrow;
  logic [PHYS_W-1:0] phys_sum;
  logic [ROW_W-1:0]  phys_row;

  // Cursor arithmetic in the access step.
  logic [COLX_W-1:0] colx;
  logic [ROW_W-1:0]  row_step;
  logic [SUM_W-1:0]  view_sum;

  // Decode of the latched item.
  assign is_print   = (cmd_r == CMD_PUT) && (char_r >= CH_SPACE) && (char_r < CH_PRINT_END);
  assign row_valid  = valid_r[row_phys_r];
  assign need_sweep = is_print && !row_valid;
  assign out_free   = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (!need_sweep) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    exec_step = 1'b0;
    commit    = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EXEC: begin
        exec_step = 1'b1;
      end
      ST_ACCESS: begin
        commit = !need_sweep;
        wr_en  = is_print;
        rd_en  = (cmd_r == CMD_READ) && in_range_r && row_valid;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_tuser);
      char_r <= in_tdata[7:0];
      back_r <= in_tdata[11:8];
      fore_r <= in_tdata[15:12];
      eot_r  <= in_tlast;
      off_r  <= in_tdata[22:16];
      rrow_r <= in_tdata[27:23];
      rcol_r <= in_tdata[34:28];
    end
  end

  // Logical row of the access and its place in the ring.
  always_comb begin
    srow_sum      = SUM_W'(view_r) + SUM_W'(rrow_r);
    read_in_range = (SUM_W'(rrow_r) < SUM_W'(SCREEN_ROWS)) &&
                    (RCOLX_W'(rcol_r) < RCOLX_W'(COLUMNS)) &&
                    (srow_sum < SUM_W'(STORE_ROWS));
    lrow          = (cmd_r == CMD_READ) ? ROW_W'(srow_sum) : row_r;
    phys_sum      = PHYS_W'(base_r) + PHYS_W'(lrow);
    if (phys_sum >= PHYS_W'(STORE_ROWS)) begin
      phys_row = ROW_W'(phys_sum - PHYS_W'(STORE_ROWS));
    end else begin
      phys_row = ROW_W'(phys_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (exec_step) begin
      row_phys_r <= phys_row;
      in_range_r <= read_in_range;
    end
  end

  // Store addresses and write data.
  assign row_addr = ADDR_W'(row_phys_r) * ADDR_W'(COLUMNS);
  assign wr_addr  = row_addr + ADDR_W'(need_sweep ? sweep_cnt_r : col_r);
  assign rd_addr  = row_addr + ADDR_W'(rcol_r);
  assign wr_data  = need_sweep ? BLANK_WORD : {back_r, fore_r, char_r};

  // Text store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Cursor, view and ring base updates for the command.
  always_comb begin
    colx     = COLX_W'(col_r);
    row_step = row_r;
    view_nxt = view_r;
    base_nxt = base_r;
    scroll   = 1'b0;
    view_sum = SUM_W'(view_r) + SUM_W'(off_r);
    case (cmd_r)
      CMD_PUT: begin
        if (char_r == CH_BS) begin
          if (col_r != '0) colx = COLX_W'(col_r) - COLX_W'(1);
        end else if (char_r == CH_TAB) begin
          colx = (COLX_W'(col_r) + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
        end else if (char_r == CH_CR) begin
          colx = '0;
        end else if (char_r == CH_LF) begin
          colx     = '0;
          row_step = row_r + ROW_W'(1);
        end else if (is_print) begin
          colx = COLX_W'(col_r) + COLX_W'(1);
        end
        // Column wrap onto the next row.
        if (colx >= COLX_W'(COLUMNS)) begin
          colx     = '0;
          row_step = row_r + ROW_W'(1);
        end
        // Reaching the last row scrolls the ring by one row.
        if (row_step == ROW_W'(STORE_ROWS - 1)) begin
          scroll   = 1'b1;
          row_step = ROW_W'(STORE_ROWS - 2);
          base_nxt = (base_r == ROW_W'(STORE_ROWS - 1)) ? '0 : base_r + ROW_W'(1);
        end
        // The view follows the cursor at the end of a string.
        if (eot_r) begin
          if (SUM_W'(row_step) >= SUM_W'(SCREEN_ROWS - 1)) begin
            view_nxt = ROW_W'(SUM_W'(row_step) - SUM_W'(SCREEN_ROWS - 1));
          end else begin
            view_nxt = '0;
          end
        end
      end
      CMD_VIEW_UP: begin
        if (SUM_W'(view_r) >= SUM_W'(off_r)) begin
          view_nxt = ROW_W'(SUM_W'(view_r) - SUM_W'(off_r));
        end else begin
          view_nxt = '0;
        end
      end
      CMD_VIEW_DOWN: begin
        if (view_sum < SUM_W'(row_r)) begin
          view_nxt = ROW_W'(view_sum);
        end else begin
          view_nxt = row_r;
        end
      end
      CMD_CLEAR: begin
        colx     = '0;
        row_step = '0;
        view_nxt = '0;
        base_nxt = '0;
      end
      default: begin
        view_nxt = view_r;
      end
    endcase
    col_nxt = COL_W'(colx);
    row_nxt = row_step;
  end

  // Console state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      view_r <= '0;
      base_r <= '0;
    end else if (commit) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      view_r <= view_nxt;
      base_r <= base_nxt;
    end
  end

  // Row marks: cleared by reset and clear, set after a blanking sweep,
  // and dropped for the row that a scroll reuses as the new last row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      sweep_cnt_r <= '0;
    end else if (state_r == ST_ACCESS) begin
      if (need_sweep) begin
        if (sweep_cnt_r == COL_W'(COLUMNS - 1)) begin
          sweep_cnt_r         <= '0;
          valid_r[row_phys_r] <= 1'b1;
        end else begin
          sweep_cnt_r <= sweep_cnt_r + COL_W'(1);
        end
      end else if (cmd_r == CMD_CLEAR) begin
        valid_r <= '0;
      end else if (scroll) begin
        valid_r[base_r] <= 1'b0;
      end
    end
  end

  // A read hits only a written row inside the screen and the store.
  always_ff @(posedge clk) begin
    if (commit) begin
      read_hit_r <= in_range_r && row_valid;
    end
  end

  // Result word.
  always_comb begin
    if (cmd_r == CMD_READ) begin
      cell_word = read_hit_r ? rd_data_r : BLANK_WORD;
    end else begin
      cell_word = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, cell_word, POS_W'(view_r), POS_W'(row_r),
                     POS_W'(col_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Checks on the sequencer and the cursor state.
  `TCS_ASSERT_NOW(a_row_below_last, 1'b1, row_r < ROW_W'(STORE_ROWS - 1), "cursor on last row")
  `TCS_ASSERT_NOW(a_col_in_range, 1'b1, COLX_W'(col_r) < COLX_W'(COLUMNS), "column out of range")
  `TCS_ASSERT_NOW(a_sweep_idle, state_r != ST_ACCESS, sweep_cnt_r == '0, "sweep left running")
  `TCS_ASSERT_NEXT(a_done_loads, load_out, out_tvalid_r && state_r == ST_IDLE, "result lost")
  `TCS_ASSERT_NOW(a_result_source, $rose(out_tvalid_r), $past(state_r == ST_DONE), "stray result")

endmodule
